// ===== rtl/mck_pkg.sv =====
// Shared types, code tables and the character decoder for the Morse keyer.
package mck_pkg;

	// Segment lengths in dot units
	localparam logic [2:0] UNITS_DOT    = 3'd1;
	localparam logic [2:0] UNITS_DASH   = 3'd3;
	localparam logic [2:0] UNITS_SYMGAP = 3'd1;
	localparam logic [2:0] UNITS_LETGAP = 3'd3;
	localparam logic [2:0] UNITS_WORD   = 3'd7;

	// Character codes that bound the coded ranges
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CHAR_LOWER = 8'h61;
	localparam logic [7:0] CHAR_DIGIT = 8'h30;

	// Symbol count and pattern; bit (len-1) is the first symbol, 1 = dash
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] pat;
	} code_t;

	// One queued character as kept in the queue memory
	typedef struct packed {
		logic       space;
		logic [2:0] len;
		logic [4:0] pat;
	} entry_t;

	typedef struct packed {
		logic   coded;
		entry_t entry;
	} decode_t;

	localparam code_t LETTER_TAB [26] = '{
		'{3'd2, 5'd1},  '{3'd4, 5'd8},  '{3'd4, 5'd10}, '{3'd3, 5'd4},
		'{3'd1, 5'd0},  '{3'd4, 5'd2},  '{3'd3, 5'd6},  '{3'd4, 5'd0},
		'{3'd2, 5'd0},  '{3'd4, 5'd7},  '{3'd3, 5'd5},  '{3'd4, 5'd4},
		'{3'd2, 5'd3},  '{3'd2, 5'd2},  '{3'd3, 5'd7},  '{3'd4, 5'd6},
		'{3'd4, 5'd13}, '{3'd3, 5'd2},  '{3'd3, 5'd0},  '{3'd1, 5'd1},
		'{3'd3, 5'd1},  '{3'd4, 5'd1},  '{3'd3, 5'd3},  '{3'd4, 5'd9},
		'{3'd4, 5'd11}, '{3'd4, 5'd12}
	};

	localparam code_t DIGIT_TAB [10] = '{
		'{3'd5, 5'd31}, '{3'd5, 5'd15}, '{3'd5, 5'd7}, '{3'd5, 5'd3},
		'{3'd5, 5'd1},  '{3'd5, 5'd0},  '{3'd5, 5'd16}, '{3'd5, 5'd24},
		'{3'd5, 5'd28}, '{3'd5, 5'd30}
	};

	// Map an ASCII code to its queue entry; uncoded characters clear coded
	function automatic decode_t decode_char(input logic [7:0] c);
		decode_t    d;
		logic [7:0] diff;
		code_t      code;
		d    = '0;
		diff = '0;
		code = '0;
		case (c) inside
			CHAR_SPACE: begin
				d.coded       = 1'b1;
				d.entry.space = 1'b1;
			end
			[8'h41:8'h5A]: begin
				diff          = c - CHAR_UPPER;
				code          = LETTER_TAB[diff[4:0]];
				d.coded       = 1'b1;
				d.entry.len   = code.len;
				d.entry.pat   = code.pat;
			end
			[8'h61:8'h7A]: begin
				diff          = c - CHAR_LOWER;
				code          = LETTER_TAB[diff[4:0]];
				d.coded       = 1'b1;
				d.entry.len   = code.len;
				d.entry.pat   = code.pat;
			end
			[8'h30:8'h39]: begin
				diff          = c - CHAR_DIGIT;
				code          = DIGIT_TAB[diff[3:0]];
				d.coded       = 1'b1;
				d.entry.len   = code.len;
				d.entry.pat   = code.pat;
			end
			default: begin
				d.coded = 1'b0;
			end
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/mck_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mck_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/morse_character_keyer.sv =====
// Top level of the Morse character keyer: input queue, serializer and output register.
//
// Each accepted ASCII character is decoded on entry and queued in a small RAM
// of QUEUE_DEPTH entries; codes other than space, letters and digits are taken
// and dropped. The serializer sends one key segment per cycle while out_stall is
// low: a character of n symbols gives 2n segments (dot 1 on or dash 3 on, each
// followed by 1 off, the final one by 3 off with last set), and a space gives
// one 7-unit off segment. The next queued entry is fetched by a registered RAM
// read once the current character is done. Input is taken every cycle until the
// queue is full; the output register lets the serializer advance while its
// result is being taken.
module morse_character_keyer
	import mck_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       key_on,
	output logic [2:0] units,
	output logic       last
);

	localparam int AW     = $clog2(QUEUE_DEPTH);
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int EntryW = $bits(entry_t);

	// Queue control
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          rd_pend_s1;
	decode_t       dec;
	logic          in_fire, wr_en, rd_en;
	logic [EntryW-1:0] rd_data;
	entry_t        rd_entry;

	// Serializer
	logic       cur_valid_q;
	logic       cur_space_q;
	logic [2:0] cur_len_q;
	logic [4:0] cur_pat_q;
	logic [3:0] seg_idx_q;
	logic [2:0] sym, bit_idx, last_sym;
	logic       gap, seg_final, seg_adv, cur_done;
	logic       seg_on, seg_last;
	logic [2:0] seg_units;

	// Output register
	logic       out_valid_q, key_on_q, last_q;
	logic [2:0] units_q;
	logic       out_load_ok;

	// Decode on entry and queue only coded characters
	assign dec      = decode_char(char_code);
	assign in_stall = (count_q == CW'(QUEUE_DEPTH));
	assign in_fire  = in_valid && !in_stall;
	assign wr_en    = in_fire && dec.coded;

	// Pick the current segment from the serializer state
	assign sym      = seg_idx_q[3:1];
	assign gap      = seg_idx_q[0];
	assign last_sym = cur_len_q - 3'd1;
	assign bit_idx  = last_sym - sym;

	always_comb begin
		seg_on    = 1'b0;
		seg_units = UNITS_WORD;
		seg_last  = 1'b1;
		if (!cur_space_q) begin
			if (!gap) begin
				seg_on    = 1'b1;
				seg_units = cur_pat_q[bit_idx] ? UNITS_DASH : UNITS_DOT;
				seg_last  = 1'b0;
			end else if (sym == last_sym) begin
				seg_units = UNITS_LETGAP;
				seg_last  = 1'b1;
			end else begin
				seg_units = UNITS_SYMGAP;
				seg_last  = 1'b0;
			end
		end
	end

	assign seg_final   = seg_last;
	assign out_load_ok = !out_valid_q || !out_stall;
	assign seg_adv     = cur_valid_q && out_load_ok;
	assign cur_done    = seg_adv && seg_final;

	// Fetch the next entry once the serializer frees up; one read in flight
	assign rd_en    = (count_q != '0) && !rd_pend_s1 && (!cur_valid_q || cur_done);
	assign rd_entry = entry_t'(rd_data);

	mck_ram #(
		.WIDTH (EntryW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_ptr_q),
		.wr_data (dec.entry),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// Advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
			rd_pend_s1 <= rd_en;
		end
	end

	// Load a fetched entry, step through its segments, drop it when done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			seg_idx_q   <= '0;
		end else if (rd_pend_s1) begin
			cur_valid_q <= 1'b1;
			seg_idx_q   <= '0;
		end else if (cur_done) begin
			cur_valid_q <= 1'b0;
		end else if (seg_adv) begin
			seg_idx_q <= seg_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			cur_space_q <= rd_entry.space;
			cur_len_q   <= rd_entry.len;
			cur_pat_q   <= rd_entry.pat;
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_ok) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (seg_adv) begin
			key_on_q <= seg_on;
			units_q  <= seg_units;
			last_q   <= seg_last;
		end
	end

	assign out_valid = out_valid_q;
	assign key_on    = key_on_q;
	assign units     = units_q;
	assign last      = last_q;

	// A fetched entry always lands in an empty serializer
	assert property (@(posedge clk) disable iff (!arst_n) rd_pend_s1 |-> !cur_valid_q)
		else $error("queue read returned while serializer busy");

	// Occupancy never exceeds the queue depth
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(QUEUE_DEPTH))
		else $error("queue occupancy overflow");

	// A character never spans more than ten segments
	assert property (@(posedge clk) disable iff (!arst_n) cur_valid_q |-> seg_idx_q <= 4'd9)
		else $error("segment index past end of character");

	// The closing segment of a character is always a key-up gap
	assert property (@(posedge clk) disable iff (!arst_n) out_valid_q && last_q |-> !key_on_q)
		else $error("final segment with key down");

endmodule

// ===== sim/morse_character_keyer_tb.sv =====
// Self-checking testbench for the Morse character keyer: directed and random characters.
`timescale 1ns / 1ps

module morse_character_keyer_tb
	import mck_pkg::*;
;

	localparam logic KEY_DOWN = 1'b1;
	localparam logic KEY_UP   = 1'b0;

	localparam int RANDOM_CHARS = 120;
	localparam int IDLE_PCT     = 17;
	localparam int DRAIN_CYCLES = 30;

	// One key segment as seen on the result channel
	typedef struct packed {
		logic       key_on;
		logic [2:0] units;
		logic       last;
	} seg_t;

	// Predict key segments per character and check them in order
	class keyer_scoreboard;
		seg_t  expected_segs[$];
		int    errors    = 0;
		int    n_chars   = 0;
		int    n_dropped = 0;
		int    n_segs    = 0;
		string letter_code [26] = '{
			".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
			".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
			"...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
		};
		string digit_code [10] = '{
			"-----", ".----", "..---", "...--", "....-",
			".....", "-....", "--...", "---..", "----."
		};

		// Dot-dash pattern of a coded letter or digit, empty otherwise
		function string morse_pattern(logic [7:0] c);
			if (c >= CHAR_UPPER && c <= CHAR_UPPER + 8'd25)
				return letter_code[c - CHAR_UPPER];
			if (c >= CHAR_LOWER && c <= CHAR_LOWER + 8'd25)
				return letter_code[c - CHAR_LOWER];
			if (c >= CHAR_DIGIT && c <= CHAR_DIGIT + 8'd9)
				return digit_code[c - CHAR_DIGIT];
			return "";
		endfunction

		function bit is_coded(logic [7:0] c);
			return (c == CHAR_SPACE) || (morse_pattern(c).len() > 0);
		endfunction

		// Queue the segments that one accepted character should produce
		function void note_char(logic [7:0] c);
			string p;
			seg_t  s;
			p = morse_pattern(c);
			n_chars++;
			if (c == CHAR_SPACE) begin
				s = '{KEY_UP, UNITS_WORD, 1'b1};
				expected_segs.push_back(s);
			end else if (p.len() == 0) begin
				n_dropped++;
			end else begin
				for (int i = 0; i < p.len(); i++) begin
					s = '{KEY_DOWN, (p[i] == "-") ? UNITS_DASH : UNITS_DOT, 1'b0};
					expected_segs.push_back(s);
					if (i + 1 < p.len())
						s = '{KEY_UP, UNITS_SYMGAP, 1'b0};
					else
						s = '{KEY_UP, UNITS_LETGAP, 1'b1};
					expected_segs.push_back(s);
				end
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30)
				$display("ERROR @%0t: %s", $realtime, msg);
		endtask

		// Compare one taken segment against the oldest expectation
		task check_seg(logic k, logic [2:0] u, logic l);
			seg_t want;
			if (expected_segs.size() == 0) begin
				report($sformatf("unexpected segment key_on=%0b units=%0d last=%0b", k, u, l));
				return;
			end
			want = expected_segs.pop_front();
			n_segs++;
			if (k !== want.key_on)
				report($sformatf("segment %0d key_on %0b, want %0b", n_segs, k, want.key_on));
			if (u !== want.units)
				report($sformatf("segment %0d units %0d, want %0d", n_segs, u, want.units));
			if (l !== want.last)
				report($sformatf("segment %0d last %0b, want %0b", n_segs, l, want.last));
		endtask

		function int pending();
			return expected_segs.size();
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] char_code = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       key_on;
	logic [2:0] units;
	logic       last;

	bit              idle_on = 1'b1;
	keyer_scoreboard sb      = new();

	// Edge cases: range bounds on both sides, the letter F, space, high codes
	localparam int N_DIRECTED = 23;
	localparam logic [7:0] DIRECTED_CHARS [N_DIRECTED] = '{
		8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h46, 8'h66, 8'h20,
		8'h00, 8'hFF, 8'h80, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A,
		8'h45, 8'h54, 8'h35, 8'h1F, 8'h51
	};

	morse_character_keyer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key_on    (key_on),
		.units     (units),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result channel at random while idling is enabled
	always @(negedge clk) begin
		out_stall <= arst_n && idle_on && ($urandom_range(99) < IDLE_PCT);
	end

	// Check every segment taken on the result channel
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_seg(key_on, units, last);
	end

	// Offer one character, with random idle cycles ahead of it; called at a falling edge
	task send_char(input logic [7:0] c);
		while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_char(c);
		@(negedge clk);
	endtask

	// Mostly letters of both cases and digits, with spaces and arbitrary codes mixed in
	function automatic logic [7:0] random_char();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 8'($urandom_range(255));
		if (r < 15)
			return CHAR_SPACE;
		if (r < 30)
			return 8'(CHAR_DIGIT + $urandom_range(9));
		if (r < 65)
			return 8'(CHAR_UPPER + $urandom_range(25));
		return 8'(CHAR_LOWER + $urandom_range(25));
	endfunction

	initial begin
		int         coded_sent;
		logic [7:0] c;
		coded_sent = 0;

		// Hold reset, then release at a falling edge
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_CHARS[i])
			send_char(DIRECTED_CHARS[i]);

		// Random characters, with a stretch in the middle that runs without idling
		while (coded_sent < RANDOM_CHARS) begin
			idle_on = !(coded_sent >= 60 && coded_sent < 100);
			c = random_char();
			send_char(c);
			if (sb.is_coded(c))
				coded_sent++;
		end
		idle_on = 1'b1;
		in_valid <= 1'b0;

		// Drain outstanding segments, then watch for strays
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters (%0d uncoded and dropped), checked %0d key segments.",
			sb.n_chars, sb.n_dropped, sb.n_segs);
		$display("Mismatches found: %0d", sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("Timeout: %0d segments still expected", sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
